/* sv/wcea_pkg.sv */
// Shared constants and types for the wrapping counter elapsed accumulator.
// No dependencies.
`timescale 1ns / 1ps

package wcea_pkg;

  // Fixed widths of the request, response and configuration payloads
  localparam int unsigned SampleW   = 64;
  localparam int unsigned TicksOutW = 64;
  localparam int unsigned PerOutW   = 32;
  localparam int unsigned CfgW      = 64;

  // counter_max after reset: all ones
  localparam logic [CfgW-1:0] CfgMaxRst = {CfgW{1'b1}};

  // Control passed from the front stage to the accumulator
  typedef struct packed {
    logic fire;      // one request steps the accumulator this cycle
    logic restart;   // clear totals and history first
    logic rejected;  // sample above counter_max, history untouched
  } wcea_ctl_t;

endpackage

/* sv/wcea_if.sv */
// Request and response channel interfaces (valid/ready).
// Depends on wcea_pkg.
`timescale 1ns / 1ps

interface wcea_req_if
  import wcea_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_value;
  logic               restart;

  modport source (output valid, sample_value, restart, input ready);
  modport sink   (input valid, sample_value, restart, output ready);
endinterface

interface wcea_rsp_if
  import wcea_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [TicksOutW-1:0] total_ticks;
  logic [PerOutW-1:0]   total_periods;
  logic                 sample_rejected;

  modport source (output valid, total_ticks, total_periods, sample_rejected, input ready);
  modport sink   (input valid, total_ticks, total_periods, sample_rejected, output ready);
endinterface

/* sv/wcea_acc.sv */
// Accumulator state and combinational step logic (history, mixed-radix total).
// Depends on wcea_pkg.
`timescale 1ns / 1ps

module wcea_acc
  import wcea_pkg::*;
#(
  parameter int unsigned TICK_WIDTH   = 64,
  parameter int unsigned PERIOD_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wcea_ctl_t               ctl_i,
  input  logic [TICK_WIDTH-1:0]   sample_i,
  input  logic [TICK_WIDTH-1:0]   max_i,
  output logic [TICK_WIDTH-1:0]   acc_ticks_o,
  output logic [PERIOD_WIDTH-1:0] acc_periods_o
);

  localparam logic [PERIOD_WIDTH-1:0] PerMax = {PERIOD_WIDTH{1'b1}};

  logic [TICK_WIDTH-1:0]   last_q, last_d;
  logic [PERIOD_WIDTH-1:0] wraps_q, wraps_d;
  logic [TICK_WIDTH-1:0]   ticks_q, ticks_d;
  logic [PERIOD_WIDTH-1:0] per_q, per_d;
  logic                    await_q, await_d;

  // state as seen after an optional restart
  logic [TICK_WIDTH-1:0]   cur_last, cur_ticks;
  logic [PERIOD_WIDTH-1:0] cur_wraps, cur_per;
  logic                    cur_await;

  logic                    lt, wrap_inc;
  logic [TICK_WIDTH-1:0]   dt, room;

  always_comb begin
    cur_last  = ctl_i.restart ? '0 : last_q;
    cur_wraps = ctl_i.restart ? '0 : wraps_q;
    cur_ticks = ctl_i.restart ? '0 : ticks_q;
    cur_per   = ctl_i.restart ? '0 : per_q;
    cur_await = ctl_i.restart ? 1'b1 : await_q;

    lt       = sample_i < cur_last;
    wrap_inc = lt && (cur_wraps != PerMax);

    // delta ticks; a wrap never leaves dt above max
    priority if (!lt) begin
      dt = sample_i - cur_last;
    end else if (!wrap_inc) begin
      dt = '0;                         // wrap count pinned: clamp
    end else if (cur_last > max_i) begin
      dt = sample_i;                   // max lowered under history
    end else begin
      dt = sample_i + (max_i - cur_last) + 1'b1;
    end
    room = max_i - dt;

    last_d  = cur_last;
    wraps_d = cur_wraps;
    ticks_d = cur_ticks;
    per_d   = cur_per;
    await_d = cur_await;

    if (!ctl_i.rejected) begin
      last_d  = sample_i;
      wraps_d = cur_wraps + PERIOD_WIDTH'(wrap_inc);
      await_d = 1'b0;
      if (!cur_await) begin
        if (room >= cur_ticks) begin
          ticks_d = cur_ticks + dt;
        end else begin
          ticks_d = cur_ticks - (room + 1'b1);
          per_d   = (cur_per == PerMax) ? cur_per : cur_per + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      wraps_q <= '0;
      ticks_q <= '0;
      per_q   <= '0;
      await_q <= 1'b1;
    end else if (ctl_i.fire) begin
      last_q  <= last_d;
      wraps_q <= wraps_d;
      ticks_q <= ticks_d;
      per_q   <= per_d;
      await_q <= await_d;
    end
  end

  assign acc_ticks_o   = ticks_q;
  assign acc_periods_o = per_q;

  // period total only grows between restarts
  a_per_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire && !ctl_i.restart |=> per_q >= $past(per_q))
    else $error("period total decreased without restart");

  // an accepted sample primes history
  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire && !ctl_i.rejected |=> !await_q && last_q == $past(sample_i))
    else $error("valid sample did not update history");

  // a rejected sample leaves history alone
  a_rej_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire && ctl_i.rejected && !ctl_i.restart |=>
      $stable(last_q) && $stable(wraps_q) && $stable(ticks_q))
    else $error("rejected sample changed history");

endmodule

/* sv/wrapping_counter_elapsed_accumulator.sv */
// Top level: request stage, configuration register, accumulator and response.
// Depends on wcea_pkg, wcea_if (wcea_req_if, wcea_rsp_if) and wcea_acc.
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// -------  ---  ------------  ------------------------------------------------
// req_i    in   valid/ready   sample_value[63:0], restart
// rsp_o    out  valid/ready   total_ticks[63:0], total_periods[31:0],
//                             sample_rejected
// cfg      in   cfg_we_i      cfg_wdata_i[63:0] -> counter_max
//
// One request per cycle sustained while rsp_o takes each response without stalling.
// Stage one registers the request and the range check; the accumulator's
// compare/subtract/add chain then updates the totals, which drive the response.
// Reset clears the history, totals and counter_max (to all ones); no sweep.
// Response stall holds the state; a fresh request is still taken while the
// front stage is empty.

module wrapping_counter_elapsed_accumulator
  import wcea_pkg::*;
#(
  parameter int unsigned TICK_WIDTH   = 64,
  parameter int unsigned PERIOD_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  wcea_req_if.sink         req_i,
  wcea_rsp_if.source       rsp_o
);

  // counter_max register
  logic [CfgW-1:0] cmax_q;
  logic [TICK_WIDTH-1:0] max_eff;   // counter_max under the tick mask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmax_q <= CfgMaxRst;
    end else if (cfg_we_i) begin
      cmax_q <= cfg_wdata_i;
    end
  end

  assign max_eff = cmax_q[TICK_WIDTH-1:0];

  // front stage: captured request plus range check
  logic                  s1_vld_q;
  logic [TICK_WIDTH-1:0] s1_samp_q;
  logic                  s1_rst_q;
  logic                  s1_rej_q;
  logic                  rej_in;

  // response stage
  logic rsp_vld_q;
  logic rsp_rej_q;

  logic advance;   // front stage moves into the accumulator/response
  logic accept;

  assign rej_in  = req_i.sample_value > SampleW'(max_eff);
  assign advance = s1_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !s1_vld_q || advance;
  assign accept  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  // payload only; no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_samp_q <= req_i.sample_value[TICK_WIDTH-1:0];
      s1_rst_q  <= req_i.restart;
      s1_rej_q  <= rej_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
      rsp_rej_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
      rsp_rej_q <= s1_rej_q;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  wcea_ctl_t             ctl;
  logic [TICK_WIDTH-1:0]   acc_ticks;
  logic [PERIOD_WIDTH-1:0] acc_per;
  logic [63:0]             per_ext;

  assign ctl.fire     = advance;
  assign ctl.restart  = s1_rst_q;
  assign ctl.rejected = s1_rej_q;

  // totals registers double as the response payload: they only move when
  // the previous response has gone out
  wcea_acc #(
    .TICK_WIDTH  (TICK_WIDTH),
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sample_i     (s1_samp_q),
    .max_i        (max_eff),
    .acc_ticks_o  (acc_ticks),
    .acc_periods_o(acc_per)
  );

  assign per_ext = 64'(acc_per);

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.total_ticks     = TicksOutW'(acc_ticks);
  assign rsp_o.total_periods   = per_ext[PerOutW-1:0];
  assign rsp_o.sample_rejected = rsp_rej_q;

  // a stalled response never gets overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp_o.ready |-> !advance)
    else $error("response overwritten while stalled");

  // the reject flag travels with the request that moved into the response
  a_rej_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_vld_q && rsp_rej_q == $past(s1_rej_q))
    else $error("response flag does not follow request");

  // front stage only drains into an open response slot
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !advance |=> s1_vld_q && $stable(s1_samp_q))
    else $error("front stage lost a request");

endmodule

/* verif/tb_wrapping_counter_elapsed_accumulator.sv */
// Self-checking bench for wrapping_counter_elapsed_accumulator: drives counter samples,
// predicts the running totals and compares every response. Depends on wcea_pkg and wcea_if.
`timescale 1ns / 1ps

module tb_wrapping_counter_elapsed_accumulator;
  import wcea_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int unsigned DRAIN_CYCLES = 6;       // front stage and response stage plus margin
  localparam int unsigned HOLD_CYCLES  = 300;     // long response stall, fills the pipe
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS  = 60;

  // One response as the block reports it
  typedef struct packed {
    logic [TicksOutW-1:0] ticks;
    logic [PerOutW-1:0]   periods;
    logic                 rejected;
  } totals_t;

  // Tracks the accumulator state and queues the totals each request should produce
  class elapsed_ledger;
    logic [CfgW-1:0]      span_max;
    logic [SampleW-1:0]   last_sample;
    logic [31:0]          last_wraps;
    logic [TicksOutW-1:0] acc_ticks;
    logic [31:0]          acc_periods;
    bit                   priming;
    totals_t              owed_totals[$];
    int unsigned          errors;

    function new();
      span_max = CfgMaxRst;
      errors   = 0;
      clear_history();
    endfunction

    function void clear_history();
      last_sample = '0;
      last_wraps  = '0;
      acc_ticks   = '0;
      acc_periods = '0;
      priming     = 1'b1;
    endfunction

    function void set_max(logic [CfgW-1:0] v);
      span_max = v;
    endfunction

    function logic [31:0] add_periods(logic [31:0] a, logic [31:0] b);
      if (a == '1 || b > ~a) return '1;
      return a + b;
    endfunction

    function int unsigned pending();
      return owed_totals.size();
    endfunction

    // Accepted request: advance the model and queue the totals it should report
    function void note_sample(logic [SampleW-1:0] s, logic restart);
      logic [31:0]          wraps_now;
      logic [31:0]          wrap_step;
      logic [TicksOutW-1:0] dt;
      logic                 bad;
      totals_t              owed;
      bad = (s > span_max);
      if (restart) clear_history();
      if (!bad) begin
        wraps_now = last_wraps;
        if (s < last_sample && last_wraps != '1) wraps_now = last_wraps + 1;
        if (priming) begin
          priming = 1'b0;
        end else begin
          wrap_step = wraps_now - last_wraps;
          if (s >= last_sample) begin
            dt = s - last_sample;
          end else if (wrap_step == 0) begin
            dt = '0;  // wrap count pinned: backward step adds nothing
          end else begin
            // the wrap itself is counted through the tick carry below
            wrap_step = wrap_step - 1;
            if (last_sample > span_max) dt = s;
            else dt = s + (span_max - last_sample) + 1;
          end
          acc_periods = add_periods(acc_periods, wrap_step);
          if (span_max - dt >= acc_ticks) begin
            acc_ticks = acc_ticks + dt;
          end else begin
            acc_periods = add_periods(acc_periods, 32'd1);
            acc_ticks   = acc_ticks - ((span_max - dt) + 1);
          end
        end
        last_sample = s;
        last_wraps  = wraps_now;
      end
      owed.ticks    = acc_ticks;
      owed.periods  = acc_periods;
      owed.rejected = bad;
      owed_totals.push_back(owed);
    endfunction

    function void check_totals(totals_t got);
      totals_t owed;
      if (owed_totals.size() == 0) begin
        errors++;
        $display("%0t: response with nothing outstanding, actual %h", $time, got);
        return;
      end
      owed = owed_totals.pop_front();
      if (got.ticks !== owed.ticks) begin
        errors++;
        $display("%0t: total_ticks expected %h actual %h", $time, owed.ticks, got.ticks);
      end
      if (got.periods !== owed.periods) begin
        errors++;
        $display("%0t: total_periods expected %h actual %h", $time, owed.periods,
                 got.periods);
      end
      if (got.rejected !== owed.rejected) begin
        errors++;
        $display("%0t: sample_rejected expected %b actual %b", $time, owed.rejected,
                 got.rejected);
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  wcea_req_if req_ch ();
  wcea_rsp_if rsp_ch ();

  wrapping_counter_elapsed_accumulator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  elapsed_ledger ledger = new();

  // Stimulus-side view of the programmed maximum and the simulated counter position
  logic [CfgW-1:0]    cur_max;
  logic [SampleW-1:0] walk_pos;
  bit                 steady;       // no idling on either side while set
  bit                 hold_wanted;  // ask the response side for one long stall

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 28);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Uniform-ish value in [0, limit]
  function automatic logic [63:0] at_most(logic [63:0] limit);
    logic [63:0] r;
    r = rand64();
    if (limit == '1) return r;
    return r % (limit + 1);
  endfunction

  // Present one request, holding it until the block takes it. Entered and left at a
  // falling edge; valid stays high on return so back-to-back requests need no gap.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic restart);
    while (take_gap()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.sample_value <= s;
    req_ch.restart      <= restart;
    do @(posedge clk_i); while (!req_ch.ready);
    ledger.note_sample(s, restart);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every outstanding response is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  // Register writes only land on an idle block
  task automatic write_counter_max(input logic [CfgW-1:0] v);
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we  <= 1'b0;
    cur_max = v;
    ledger.set_max(v);
  endtask

  // Next sample: mostly a counter moving forward (wrapping at cur_max), plus random
  // in-range jumps, the range ends, out-of-range readings and the odd restart.
  task automatic send_random_sample();
    logic [64:0] sum;
    logic [63:0] s;
    logic [63:0] step;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (walk_pos > cur_max) walk_pos = at_most(cur_max);
    if (pick < 70 && pick >= 55) begin
      s = at_most(cur_max);
      walk_pos = s;
    end else if (pick < 78 && pick >= 70) begin
      s = $urandom_range(0, 1) ? cur_max : '0;
      walk_pos = s;
    end else if (pick < 90 && pick >= 78 && cur_max != '1) begin
      s = cur_max + 1 + (rand64() % (~cur_max));  // above the range, history untouched
    end else begin
      if ($urandom_range(0, 1)) step = $urandom_range(0, 40);
      else step = at_most(cur_max) >> $urandom_range(1, 6);
      sum = {1'b0, walk_pos} + {1'b0, step};
      while (sum > {1'b0, cur_max}) sum = sum - ({1'b0, cur_max} + 65'd1);
      walk_pos = sum[63:0];
      s = walk_pos;
    end
    send_sample(s, $urandom_range(0, 99) < 5);
  endtask

  // Response side: random back-pressure plus one long stall on request
  initial begin : rsp_driver
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !take_gap();
      end
    end
  end

  // Responses are checked at the rising edge they are taken
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      ledger.check_totals({rsp_ch.total_ticks, rsp_ch.total_periods,
                           rsp_ch.sample_rejected});
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [CfgW-1:0] phase_max;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.sample_value = '0;
    req_ch.restart      = 1'b0;
    steady              = 1'b0;
    hold_wanted         = 1'b0;
    cur_max             = CfgMaxRst;
    walk_pos            = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset maximum, full-range extremes and a wrap across all ones
    send_sample(64'd0, 1'b1);
    send_sample('1, 1'b0);
    send_sample(64'd3, 1'b0);
    send_sample(64'd3, 1'b0);
    send_sample(64'd2, 1'b0);
    send_sample(64'h8000_0000_0000_0000, 1'b0);

    // Small period: rejected reading with restart keeps priming pending, wraps carry
    write_counter_max(64'd1000);
    send_sample(64'd2000, 1'b1);
    send_sample(64'd999, 1'b0);
    send_sample(64'd1001, 1'b0);
    send_sample(64'd0, 1'b0);
    send_sample(64'd999, 1'b0);
    send_sample(64'd500, 1'b0);
    send_sample('1, 1'b0);

    // Smallest maximum; history (500) now sits above it
    write_counter_max(64'd1);
    send_sample(64'd1, 1'b0);
    send_sample(64'd0, 1'b0);
    send_sample(64'd1, 1'b0);
    send_sample(64'd2, 1'b0);
    send_sample(64'd0, 1'b1);
    send_sample(64'd1, 1'b0);

    // Build a large tick total, then lower the maximum far below history and total
    write_counter_max(64'h0000_0000_FFFF_FFFF);
    send_sample(64'h0000_0000_FFFF_FF00, 1'b1);
    send_sample(64'h0000_0000_FFFF_FFFF, 1'b0);
    send_sample(64'h0000_0000_7FFF_FFFF, 1'b0);
    send_sample(64'h0000_0000_FFFF_FFF0, 1'b0);
    write_counter_max(64'd100);
    send_sample(64'd50, 1'b0);
    send_sample(64'd60, 1'b0);
    send_sample(64'd10, 1'b0);
    send_sample(64'd99, 1'b0);

    // Random phases over a spread of maxima, ending on the reset value
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p % 6)
        0:       phase_max = 64'd1;
        1:       phase_max = $urandom_range(2, 20);
        2:       phase_max = $urandom_range(21, 5000);
        3:       phase_max = {32'd0, $urandom} | 64'd1;
        4:       phase_max = rand64() | 64'd1;
        default: phase_max = '1;
      endcase
      if (p == RAND_PHASES - 1) phase_max = '1;
      write_counter_max(phase_max);
      steady = (p == 3);
      if (p == 4) hold_wanted = 1'b1;  // pipe fills and the request side stalls
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) send_random_sample();
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
